// ===== hdl/aip_pkg.sv =====
// aip_pkg: shared types and constants for the ASCII integer parser.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none

package aip_pkg;

    // default sizes handed to the top level
    localparam int MAX_WIDTH_DFLT  = 512;
    localparam int VALUE_BITS_DFLT = 32;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KIND  = 2'd0,
        REG_WIDTH = 2'd1,
        REG_SHORT = 2'd2
    } t_reg_idx;

    // number kinds
    localparam logic [2:0] KIND_DEC_S = 3'd0;
    localparam logic [2:0] KIND_AUTO  = 3'd1;
    localparam logic [2:0] KIND_OCT   = 3'd2;
    localparam logic [2:0] KIND_DEC_U = 3'd3;
    localparam logic [2:0] KIND_HEX   = 3'd4;
    localparam logic [2:0] KIND_BIN   = 3'd5;

    // result status
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_DIGITS = 2'd1;
    localparam logic [1:0] ST_EOF       = 2'd2;

    // characters
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [3:0] DIGIT_TEN = 4'd10;

    typedef enum logic [2:0] {
        PH_SKIP   = 3'd0,
        PH_SIGN   = 3'd1,
        PH_ZERO   = 3'd2,
        PH_XMARK  = 3'd3,
        PH_DIGITS = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        BASE_DEC = 2'd0,
        BASE_OCT = 2'd1,
        BASE_HEX = 2'd2,
        BASE_BIN = 2'd3
    } t_base;

    // final field state handed to the formatter
    typedef struct packed {
        logic       ok;
        logic       negative;
        logic       overflowed;
        logic       signed_kind;
        logic       short_res;
    } t_fmt_ctrl;

endpackage

`default_nettype wire

// ===== hdl/aip_if.sv =====
// aip_if: valid/ready channel interfaces for the ASCII integer parser.
// Depends on aip_pkg for the configuration port widths.
`timescale 1ns / 1ps
`default_nettype none

interface aip_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       end_of_input;

    modport source (output valid, character, end_of_input, input ready);
    modport sink   (input valid, character, end_of_input, output ready);
endinterface

interface aip_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic [1:0]  status;
    logic        pushed_back;
    logic [9:0]  number_length;

    modport source (output valid, value, status, pushed_back, number_length, input ready);
    modport sink   (input valid, value, status, pushed_back, number_length, output ready);
endinterface

interface aip_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [aip_pkg::CFG_IDX_W-1:0]   index;
    logic [aip_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/aip_format.sv =====
// aip_format: turns the finished accumulator into the result pattern
// (clamping, negation, short truncation). Depends on aip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aip_format #(
    parameter int VALUE_BITS = aip_pkg::VALUE_BITS_DFLT
) (
    input  wire aip_pkg::t_fmt_ctrl  i_ctrl,
    input  wire [VALUE_BITS-1:0]     i_acc,
    output logic [31:0]              o_value
);

    localparam logic [VALUE_BITS-1:0] SMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] SMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    logic [VALUE_BITS-1:0] neg_acc;
    logic [VALUE_BITS-1:0] v;
    logic [63:0]           v_ext;

    assign neg_acc = VALUE_BITS'(0) - i_acc;

    always_comb begin
        v = '0;
        if (i_ctrl.ok) begin
            if (i_ctrl.signed_kind) begin
                if (i_ctrl.negative) begin
                    v = (i_ctrl.overflowed || i_acc > SMIN) ? SMIN : neg_acc;
                end else begin
                    v = (i_ctrl.overflowed || i_acc > SMAX) ? SMAX : i_acc;
                end
            end else if (i_ctrl.overflowed) begin
                v = '1;
            end else begin
                v = i_ctrl.negative ? neg_acc : i_acc;
            end
            if (i_ctrl.short_res) begin
                v = {{(VALUE_BITS-16){1'b0}}, v[15:0]};
            end
        end
        v_ext   = 64'(v);
        o_value = v_ext[31:0];
    end

endmodule

`default_nettype wire

// ===== hdl/ascii_integer_parser.sv =====
// ascii_integer_parser: scanf-style integer field conversion, one character per item.
// An accepted item lands in the input register; the per-character step then consumes it and,
// where the item ends a field, loads the result register, waiting while the output is stalled.
// Throughput: one item per cycle, set by the per-character step between the input
// register and the result register; stalls only on output backpressure.
// Reset (i_rst_n low, synchronous): channels empty, parser skips whitespace,
// registers return to signed decimal, width 512, full-width result.
// Depends on aip_pkg, aip_if, aip_format.
`timescale 1ns / 1ps
`default_nettype none

module ascii_integer_parser #(
    parameter int MAX_WIDTH  = aip_pkg::MAX_WIDTH_DFLT,
    parameter int VALUE_BITS = aip_pkg::VALUE_BITS_DFLT
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    aip_cfg_if.sink     i_cfg,
    aip_in_if.sink      i_in,
    aip_out_if.source   o_out
);

    // width counter holds up to MAX_WIDTH itself
    localparam int WLW = $clog2(MAX_WIDTH + 1);
    localparam int VW  = VALUE_BITS;

    localparam int MAX_WIDTH_RESET = 512;

    // ---------------------------------------------------------------
    // Configuration registers; writes are always taken.
    // ---------------------------------------------------------------
    logic [2:0] r_kind;
    logic [9:0] r_width;
    logic       r_short;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= aip_pkg::KIND_DEC_S;
            r_width <= 10'(MAX_WIDTH_RESET);
            r_short <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (aip_pkg::t_reg_idx'(i_cfg.index))
                aip_pkg::REG_KIND:  r_kind  <= i_cfg.data[2:0];
                aip_pkg::REG_WIDTH: r_width <= i_cfg.data;
                aip_pkg::REG_SHORT: r_short <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // kinds 6 and 7 behave as signed decimal
    logic [2:0] kind;
    always_comb begin
        kind = (r_kind > aip_pkg::KIND_BIN) ? aip_pkg::KIND_DEC_S : r_kind;
    end

    // width 0 or beyond MAX_WIDTH means MAX_WIDTH
    logic [WLW-1:0] eff_width;
    assign eff_width = (r_width == 10'd0 || 32'(r_width) > 32'(MAX_WIDTH)) ?
                       WLW'(MAX_WIDTH) : WLW'(r_width);

    // ---------------------------------------------------------------
    // Input register and handshake
    // ---------------------------------------------------------------
    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_eof;
    logic       r_out_valid;
    logic       step_fire;

    assign step_fire  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || step_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_char <= i_in.character;
            r_eof  <= i_in.end_of_input;
        end
    end

    // ---------------------------------------------------------------
    // Parser state
    // ---------------------------------------------------------------
    aip_pkg::t_phase r_phase, n_phase;
    aip_pkg::t_base  r_base,  n_base;
    logic            r_neg,   n_neg;
    logic            r_sign,  n_sign;   // a sign character was taken
    logic            r_ovf,   n_ovf;
    logic [VW-1:0]   r_acc,   n_acc;
    logic [WLW-1:0]  r_wleft, n_wleft;
    logic [WLW-1:0]  r_len,   n_len;

    // character classes
    logic       is_ws, is_sign, is_zero, is_x;
    logic [3:0] dval;
    logic       dhex;     // any hex digit
    logic       dok;      // digit valid in the walked base

    always_comb begin
        is_ws   = (r_char == aip_pkg::CH_SPACE) ||
                  (r_char >= aip_pkg::CH_TAB && r_char <= aip_pkg::CH_CR);
        is_sign = (r_char == aip_pkg::CH_MINUS) || (r_char == aip_pkg::CH_PLUS);
        is_zero = (r_char == aip_pkg::CH_ZERO);
        is_x    = (r_char == aip_pkg::CH_LX) || (r_char == aip_pkg::CH_UX);
        dhex    = 1'b1;
        if (r_char >= aip_pkg::CH_ZERO && r_char <= aip_pkg::CH_NINE) begin
            dval = 4'(r_char - aip_pkg::CH_ZERO);
        end else if (r_char >= aip_pkg::CH_LA && r_char <= aip_pkg::CH_LF) begin
            dval = 4'(r_char - aip_pkg::CH_LA) + aip_pkg::DIGIT_TEN;
        end else if (r_char >= aip_pkg::CH_UA && r_char <= aip_pkg::CH_UF) begin
            dval = 4'(r_char - aip_pkg::CH_UA) + aip_pkg::DIGIT_TEN;
        end else begin
            dval = 4'd0;
            dhex = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Next state: walk the phases this character passes through.
    // Several phases can fall through on one character.
    // ---------------------------------------------------------------
    aip_pkg::t_phase w_phase;
    logic            f_start;     // first non-blank: field begins
    logic            f_signtk;    // sign taken
    logic            f_digit;     // digit taken
    logic            f_take;      // character taken into the field
    logic            f_badch;     // terminator (or end of input) after field start
    logic            f_eof_skip;  // end of input before any number
    logic            f_stop;
    logic            f_emit;
    logic [WLW-1:0]  wl_cur;

    always_comb begin : next_state
        w_phase    = r_phase;
        n_base     = r_base;
        f_start    = 1'b0;
        f_signtk   = 1'b0;
        f_digit    = 1'b0;
        f_take     = 1'b0;
        f_badch    = 1'b0;
        f_eof_skip = 1'b0;
        f_stop     = 1'b0;
        dok        = 1'b0;

        if (w_phase == aip_pkg::PH_SKIP) begin
            if (r_eof) begin
                f_eof_skip = 1'b1;
                f_stop     = 1'b1;
            end else if (is_ws) begin
                f_stop = 1'b1;
            end else begin
                f_start = 1'b1;
                w_phase = aip_pkg::PH_SIGN;
                unique case (kind) inside
                    aip_pkg::KIND_AUTO, aip_pkg::KIND_HEX: n_base = aip_pkg::BASE_HEX;
                    aip_pkg::KIND_OCT:                     n_base = aip_pkg::BASE_OCT;
                    aip_pkg::KIND_BIN:                     n_base = aip_pkg::BASE_BIN;
                    default:                               n_base = aip_pkg::BASE_DEC;
                endcase
            end
        end
        if (!f_stop && w_phase == aip_pkg::PH_SIGN) begin
            w_phase = aip_pkg::PH_ZERO;
            if (!r_eof && is_sign) begin
                f_signtk = 1'b1;
                f_take   = 1'b1;
                f_stop   = 1'b1;
            end
        end
        if (!f_stop && w_phase == aip_pkg::PH_ZERO) begin
            w_phase = aip_pkg::PH_DIGITS;
            if (n_base == aip_pkg::BASE_HEX && !r_eof && is_zero) begin
                w_phase = aip_pkg::PH_XMARK;
                f_take  = 1'b1;
                f_stop  = 1'b1;
            end else if (kind == aip_pkg::KIND_AUTO) begin
                n_base = aip_pkg::BASE_DEC;
            end
        end
        if (!f_stop && w_phase == aip_pkg::PH_XMARK) begin
            w_phase = aip_pkg::PH_DIGITS;
            if (!r_eof && is_x) begin
                f_take = 1'b1;
                f_stop = 1'b1;
            end else if (kind == aip_pkg::KIND_AUTO) begin
                n_base = aip_pkg::BASE_OCT;
            end
        end
        if (!f_stop) begin
            case (n_base)
                aip_pkg::BASE_DEC: dok = dhex && dval <= 4'd9;
                aip_pkg::BASE_OCT: dok = dhex && dval <= 4'd7;
                aip_pkg::BASE_BIN: dok = dhex && dval <= 4'd1;
                default:           dok = dhex;
            endcase
            if (!r_eof && dok) begin
                f_digit = 1'b1;
                f_take  = 1'b1;
            end else begin
                f_badch = 1'b1;
            end
        end

        // a take that uses up the width ends the field
        wl_cur  = f_start ? eff_width : r_wleft;
        f_emit  = f_eof_skip || f_badch || (f_take && wl_cur == WLW'(1));
        n_phase = f_emit ? aip_pkg::PH_SKIP : w_phase;
    end

    // ---------------------------------------------------------------
    // Datapath: sign, accumulate, counts, result fields
    // ---------------------------------------------------------------
    logic [VW+4:0] acc_wide;
    logic [VW+4:0] prod;
    logic [VW-1:0] acc_c;
    logic          neg_c, sign_c, ovf_c;
    logic [WLW-1:0] len_c;
    logic          no_digits;
    logic [1:0]    res_status;
    logic          res_pb;
    logic [31:0]   len_ext;
    logic [9:0]    res_len;
    aip_pkg::t_fmt_ctrl fmt_ctrl;
    logic [31:0]   res_value;

    always_comb begin : datapath
        acc_c  = f_start ? '0 : r_acc;
        neg_c  = f_start ? 1'b0 : r_neg;
        sign_c = f_start ? 1'b0 : r_sign;
        ovf_c  = f_start ? 1'b0 : r_ovf;
        len_c  = f_start ? '0 : r_len;

        // acc * base + digit by shifts; overflow shows in the top five bits
        acc_wide = (VW+5)'(acc_c);
        case (n_base)
            aip_pkg::BASE_HEX: prod = acc_wide << 4;
            aip_pkg::BASE_OCT: prod = acc_wide << 3;
            aip_pkg::BASE_BIN: prod = acc_wide << 1;
            default:           prod = (acc_wide << 3) + (acc_wide << 1);
        endcase
        prod = prod + (VW+5)'(dval);

        n_neg  = neg_c;
        n_sign = sign_c;
        if (f_signtk) begin
            n_neg  = (r_char == aip_pkg::CH_MINUS);
            n_sign = 1'b1;
        end
        n_acc = acc_c;
        n_ovf = ovf_c;
        if (f_digit && !ovf_c) begin
            if (prod[VW+4:VW] != 5'd0) begin
                n_ovf = 1'b1;
            end else begin
                n_acc = prod[VW-1:0];
            end
        end
        n_len   = len_c + WLW'(f_take);
        n_wleft = wl_cur - WLW'(f_take);

        no_digits  = (n_len == WLW'(n_sign));
        res_status = f_eof_skip ? aip_pkg::ST_EOF :
                     no_digits  ? aip_pkg::ST_NO_DIGITS : aip_pkg::ST_OK;
        res_pb     = f_badch && !r_eof;
        len_ext    = f_eof_skip ? 32'd0 : 32'(n_len);
        res_len    = len_ext[9:0];

        fmt_ctrl.ok          = (res_status == aip_pkg::ST_OK);
        fmt_ctrl.negative    = n_neg;
        fmt_ctrl.overflowed  = n_ovf;
        fmt_ctrl.signed_kind = (kind == aip_pkg::KIND_DEC_S) || (kind == aip_pkg::KIND_AUTO);
        fmt_ctrl.short_res   = r_short;
    end

    aip_format #(
        .VALUE_BITS (VALUE_BITS)
    ) u_format (
        .i_ctrl  (fmt_ctrl),
        .i_acc   (n_acc),
        .o_value (res_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= aip_pkg::PH_SKIP;
            r_base  <= aip_pkg::BASE_DEC;
            r_neg   <= 1'b0;
            r_sign  <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (step_fire) begin
            r_phase <= n_phase;
            r_base  <= n_base;
            r_neg   <= n_neg;
            r_sign  <= n_sign;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire) begin
            r_acc   <= n_acc;
            r_wleft <= n_wleft;
            r_len   <= n_len;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic [31:0] r_value;
    logic [1:0]  r_status;
    logic        r_pb;
    logic [9:0]  r_res_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_fire && f_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire && f_emit) begin
            r_value   <= res_value;
            r_status  <= res_status;
            r_pb      <= res_pb;
            r_res_len <= res_len;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.value         = r_value;
    assign o_out.status        = r_status;
    assign o_out.pushed_back   = r_pb;
    assign o_out.number_length = r_res_len;

endmodule

`default_nettype wire

// ===== hdl/aip_checker.sv =====
// aip_checker: port-level assertions for ascii_integer_parser, bound to the top level.
// Depends on aip_pkg and ascii_integer_parser.
`timescale 1ns / 1ps
`default_nettype none

module aip_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [31:0] i_value,
    input wire [1:0]  i_status,
    input wire        i_pushed_back,
    input wire [9:0]  i_number_length
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_value) &&
            $stable(i_status) && $stable(i_number_length) && $stable(i_pushed_back))
        else $error("result changed while stalled");

    // end of input before a number: empty result, nothing pushed back
    a_eof_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == aip_pkg::ST_EOF |->
            i_value == 32'd0 && i_number_length == 10'd0 && !i_pushed_back)
        else $error("end-of-input result not empty");

    // no digits: zero value, at most a sign counted
    a_no_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == aip_pkg::ST_NO_DIGITS |->
            i_value == 32'd0 && i_number_length <= 10'd1)
        else $error("failed conversion carries a value or digits");

    // no status code beyond the defined ones
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_status == aip_pkg::ST_OK || i_status == aip_pkg::ST_NO_DIGITS ||
            i_status == aip_pkg::ST_EOF)
        else $error("undefined status");

endmodule

bind ascii_integer_parser aip_checker u_aip_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_value         (o_out.value),
    .i_status        (o_out.status),
    .i_pushed_back   (o_out.pushed_back),
    .i_number_length (o_out.number_length)
);

`default_nettype wire

// ===== sim/aip_parse_checker.sv =====
// aip_parse_checker: watches the config, character and result channels of the parser,
// predicts each field result and compares it with what the block returns.
// Depends on aip_pkg and aip_if.
`timescale 1ns / 1ps

module aip_parse_checker (
    input  wire     i_clk,
    input  wire     i_rst_n,
    aip_cfg_if      i_cfg,
    aip_in_if       i_chr,
    aip_out_if      i_res,
    output int      o_fail_count,
    output int      o_pending
);

    localparam int          FIELD_MAX = aip_pkg::MAX_WIDTH_DFLT;
    localparam logic [31:0] SMAX      = 32'h7FFF_FFFF;
    localparam logic [31:0] SMIN      = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
        logic        pushed_back;
        logic [9:0]  number_length;
    } t_field_result;

    // register copies
    logic [2:0] kind_reg;
    logic [9:0] width_reg;
    logic       short_reg;

    // parser state
    aip_pkg::t_phase ph;
    aip_pkg::t_base  base_sel;
    logic            neg;
    logic            sign_seen;
    logic            ovf;
    logic [31:0]     acc;
    int unsigned     width_left;
    int unsigned     len_count;

    t_field_result field_results_q[$];
    int            mismatch_count = 0;
    int            results_seen = 0;
    int            pending_count = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = pending_count;

    function automatic logic [2:0] kind_eff();
        return (kind_reg > aip_pkg::KIND_BIN) ? aip_pkg::KIND_DEC_S : kind_reg;
    endfunction

    function automatic int radix(input aip_pkg::t_base b);
        case (b)
            aip_pkg::BASE_HEX: return 16;
            aip_pkg::BASE_OCT: return 8;
            aip_pkg::BASE_BIN: return 2;
            default:           return 10;
        endcase
    endfunction

    function automatic int digit_value(input logic [7:0] c);
        int d;
        d = -1;
        if (c >= aip_pkg::CH_ZERO && c <= aip_pkg::CH_NINE)
            d = c - aip_pkg::CH_ZERO;
        else if (c >= aip_pkg::CH_LA && c <= aip_pkg::CH_LF)
            d = c - aip_pkg::CH_LA + aip_pkg::DIGIT_TEN;
        else if (c >= aip_pkg::CH_UA && c <= aip_pkg::CH_UF)
            d = c - aip_pkg::CH_UA + aip_pkg::DIGIT_TEN;
        if (d >= radix(base_sel)) d = -1;
        return d;
    endfunction

    // builds the result of a finished field and returns to whitespace skipping
    function automatic t_field_result close_field(input logic [1:0] status, input logic pb);
        t_field_result r;
        logic [31:0]   v;
        v = '0;
        if (status == aip_pkg::ST_OK) begin
            if (kind_eff() <= aip_pkg::KIND_AUTO) begin
                if (neg) v = (ovf || acc > SMIN) ? SMIN : -acc;
                else     v = (ovf || acc > SMAX) ? SMAX : acc;
            end else if (ovf) begin
                v = '1;
            end else begin
                v = neg ? -acc : acc;
            end
            if (short_reg) v[31:16] = '0;
        end
        r.value         = v;
        r.status        = status;
        r.pushed_back   = pb;
        r.number_length = (status == aip_pkg::ST_EOF) ? 10'd0 : len_count[9:0];
        ph = aip_pkg::PH_SKIP;
        return r;
    endfunction

    function automatic t_field_result end_field(input logic pb);
        return close_field((len_count - sign_seen == 0) ? aip_pkg::ST_NO_DIGITS
                                                        : aip_pkg::ST_OK, pb);
    endfunction

    // consumes the character; the field closes once the width is used up
    function automatic bit take_char(output t_field_result r);
        len_count++;
        width_left--;
        if (width_left != 0) return 1'b0;
        r = end_field(1'b0);
        return 1'b1;
    endfunction

    function automatic bit parse_char(input logic [7:0] c, input logic eof,
                                      output t_field_result r);
        logic [2:0]  k;
        int          d;
        logic [63:0] lim;
        k = kind_eff();
        r = '0;
        if (ph == aip_pkg::PH_SKIP) begin
            if (eof) begin
                len_count = 0;
                r = close_field(aip_pkg::ST_EOF, 1'b0);
                return 1'b1;
            end
            if (c == aip_pkg::CH_SPACE || (c >= aip_pkg::CH_TAB && c <= aip_pkg::CH_CR))
                return 1'b0;
            neg        = 1'b0;
            sign_seen  = 1'b0;
            acc        = '0;
            ovf        = 1'b0;
            len_count  = 0;
            width_left = (width_reg == 0 || width_reg > FIELD_MAX) ? FIELD_MAX : width_reg;
            case (k) inside
                aip_pkg::KIND_AUTO, aip_pkg::KIND_HEX: base_sel = aip_pkg::BASE_HEX;
                aip_pkg::KIND_OCT:                     base_sel = aip_pkg::BASE_OCT;
                aip_pkg::KIND_BIN:                     base_sel = aip_pkg::BASE_BIN;
                default:                               base_sel = aip_pkg::BASE_DEC;
            endcase
            ph = aip_pkg::PH_SIGN;
        end
        if (ph == aip_pkg::PH_SIGN) begin
            ph = aip_pkg::PH_ZERO;
            if (!eof && (c == aip_pkg::CH_MINUS || c == aip_pkg::CH_PLUS)) begin
                neg       = (c == aip_pkg::CH_MINUS);
                sign_seen = 1'b1;
                return take_char(r);
            end
        end
        if (ph == aip_pkg::PH_ZERO) begin
            ph = aip_pkg::PH_DIGITS;
            if (base_sel == aip_pkg::BASE_HEX && !eof && c == aip_pkg::CH_ZERO) begin
                ph = aip_pkg::PH_XMARK;
                return take_char(r);
            end
            if (k == aip_pkg::KIND_AUTO) base_sel = aip_pkg::BASE_DEC;
        end
        if (ph == aip_pkg::PH_XMARK) begin
            ph = aip_pkg::PH_DIGITS;
            if (!eof && (c == aip_pkg::CH_LX || c == aip_pkg::CH_UX)) return take_char(r);
            if (k == aip_pkg::KIND_AUTO) base_sel = aip_pkg::BASE_OCT;
        end
        d = eof ? -1 : digit_value(c);
        if (d < 0) begin
            r = end_field(!eof);
            return 1'b1;
        end
        if (!ovf) begin
            lim = (64'hFFFF_FFFF - 64'(d)) / 64'(radix(base_sel));
            if (64'(acc) > lim) ovf = 1'b1;
            else acc = 32'(acc * radix(base_sel) + d);
        end
        return take_char(r);
    endfunction

    always @(posedge i_clk) begin : watch
        t_field_result want;
        t_field_result got;
        if (!i_rst_n) begin
            kind_reg   = aip_pkg::KIND_DEC_S;
            width_reg  = 10'd512;
            short_reg  = 1'b0;
            ph         = aip_pkg::PH_SKIP;
            base_sel   = aip_pkg::BASE_DEC;
            neg        = 1'b0;
            sign_seen  = 1'b0;
            ovf        = 1'b0;
            acc        = '0;
            width_left = 0;
            len_count  = 0;
            field_results_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    aip_pkg::REG_KIND:  kind_reg  = i_cfg.data[2:0];
                    aip_pkg::REG_WIDTH: width_reg = i_cfg.data;
                    aip_pkg::REG_SHORT: short_reg = i_cfg.data[0];
                    default: ;
                endcase
            end
            if (i_chr.valid && i_chr.ready) begin
                if (parse_char(i_chr.character, i_chr.end_of_input, want))
                    field_results_q.push_back(want);
            end
            if (i_res.valid && i_res.ready) begin
                got.value         = i_res.value;
                got.status        = i_res.status;
                got.pushed_back   = i_res.pushed_back;
                got.number_length = i_res.number_length;
                results_seen++;
                if (field_results_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d arrived with none outstanding: value %h status %0d",
                                 results_seen, got.value, got.status);
                end else begin
                    want = field_results_q.pop_front();
                    if (got.value !== want.value || got.status !== want.status ||
                        got.pushed_back !== want.pushed_back ||
                        got.number_length !== want.number_length) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("result %0d: expected value %h status %0d pb %0d len %0d",
                                     results_seen, want.value, want.status,
                                     want.pushed_back, want.number_length);
                            $display("result %0d: got      value %h status %0d pb %0d len %0d",
                                     results_seen, got.value, got.status,
                                     got.pushed_back, got.number_length);
                        end
                    end
                end
            end
        end
        pending_count = field_results_q.size();
    end

endmodule

// ===== sim/testbench.sv =====
// testbench: top of the parser simulation; drives config writes, the character stream and
// result backpressure, and prints the verdict. Checking lives in aip_parse_checker.
// Depends on aip_pkg, aip_if, ascii_integer_parser and aip_parse_checker.
`timescale 1ns / 1ps

module testbench;

    localparam int ITEM_TARGET = 1950;
    localparam int CYCLE_LIMIT = 400000;

    // index with no register behind it; writes must be harmless
    localparam logic [aip_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    // kind codes past the defined range, which behave as signed decimal
    localparam logic [2:0] KIND_ALIAS_6 = 3'd6;
    localparam logic [2:0] KIND_ALIAS_7 = 3'd7;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int         fail_count;
    int         pending;
    int         items_sent = 0;
    int         cycle_count;
    int         chr_burst = 0;   // items left in a no-gap stretch on the character side
    int         res_burst = 0;   // same for the result side
    logic [2:0] cur_kind;        // kind last written, used to shape the digits

    aip_cfg_if cfg_ch ();
    aip_in_if  chr_ch ();
    aip_out_if res_ch ();

    ascii_integer_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (chr_ch),
        .o_out   (res_ch)
    );

    aip_parse_checker u_parse_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg_ch),
        .i_chr        (chr_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Gap before the next item, drawn at random, with occasional long stretches of no gaps
    // so back-to-back traffic shows up on both channels.
    function automatic int draw_gap(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) burst_left = $urandom_range(20, 60);
        return $urandom_range(0, 5);
    endfunction

    // whitespace the parser skips: tab, LF, VT, FF, CR or space
    function automatic logic [7:0] blank_char();
        int r;
        r = $urandom_range(0, 6);
        return (r >= 5) ? aip_pkg::CH_SPACE : 8'(aip_pkg::CH_TAB + r);
    endfunction

    function automatic logic [7:0] digit_char(input int d);
        return (d < aip_pkg::DIGIT_TEN) ? 8'(aip_pkg::CH_ZERO + d)
                                        : 8'(aip_pkg::CH_LA + d - aip_pkg::DIGIT_TEN);
    endfunction

    // One character item. valid stays high into the next item when that item has no gap,
    // so valid never sees two assignments in one time step.
    task automatic send_item(input logic [7:0] c, input logic eof);
        int gap;
        gap = draw_gap(chr_burst);
        if (gap > 0) begin
            chr_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        chr_ch.valid        <= 1'b1;
        chr_ch.character    <= c;
        chr_ch.end_of_input <= eof;
        do @(posedge i_clk); while (!(chr_ch.valid && chr_ch.ready));
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    endtask

    // end of stream: the character is don't-care, so it carries random bits
    task automatic send_eof();
        send_item(8'($urandom), 1'b1);
    endtask

    task automatic write_reg(input logic [aip_pkg::CFG_IDX_W-1:0] idx,
                             input logic [aip_pkg::CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
    endtask

    // Writes all three registers, sometimes also the unused index; unused upper data bits get random values.
    task automatic set_config(input logic [2:0] kind, input logic [9:0] width,
                              input logic short_res);
        cur_kind = kind;
        write_reg(aip_pkg::REG_KIND, {7'($urandom), kind});
        write_reg(aip_pkg::REG_WIDTH, width);
        if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 10'($urandom));
        write_reg(aip_pkg::REG_SHORT, {9'($urandom), short_res});
        cfg_ch.valid <= 1'b0;
    endtask

    // Drain: every phase ends with an end-of-input item, so the parser is back to
    // skipping whitespace once the last result is in.
    task automatic settle();
        chr_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // One field of a random stream: mostly well-formed numbers in the current base,
    // with boundary values, prefixes, overflow tails, corrupted characters and noise.
    task automatic send_number_field();
        logic [31:0] val;
        logic [2:0]  k;
        string       body;
        int          pick;
        int          radix_n;
        int          n_long;
        k = (cur_kind > aip_pkg::KIND_BIN) ? aip_pkg::KIND_DEC_S : cur_kind;

        // pure noise: random bytes, any value
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) send_item(8'($urandom), 1'b0);
            return;
        end

        repeat ($urandom_range(0, 2)) send_item(blank_char(), 1'b0);
        case ($urandom_range(0, 3))
            0: send_item(aip_pkg::CH_MINUS, 1'b0);
            1: send_item(aip_pkg::CH_PLUS, 1'b0);
            default: ;
        endcase

        // boundary values around the signed, unsigned and 16-bit limits
        case ($urandom_range(0, 7))
            0: val = '0;
            1: val = $urandom_range(0, 99);
            2: val = 32'h7FFF_FFFF;
            3: val = 32'h8000_0000;
            4: val = 32'hFFFF_FFFF;
            5: val = 32'h0001_0000 - $urandom_range(0, 1);
            default: val = $urandom;
        endcase

        pick = (k == aip_pkg::KIND_AUTO) ? $urandom_range(0, 2) : 0;
        if (k == aip_pkg::KIND_HEX || (k == aip_pkg::KIND_AUTO && pick == 2)) begin
            radix_n = 16;
            body = $sformatf("%0h", val);
            for (int i = 0; i < body.len(); i++)
                if (body[i] >= aip_pkg::CH_LA && body[i] <= aip_pkg::CH_LF &&
                    $urandom_range(0, 1) == 1)
                    body[i] = body[i] - (aip_pkg::CH_LA - aip_pkg::CH_UA);
            // prefix is optional for hex, needed for auto to select hex
            if (k == aip_pkg::KIND_AUTO || $urandom_range(0, 2) != 0) begin
                if ($urandom_range(0, 1) == 1) body = {"0x", body};
                else                           body = {"0X", body};
            end
        end else if (k == aip_pkg::KIND_OCT || (k == aip_pkg::KIND_AUTO && pick == 1)) begin
            radix_n = 8;
            body = $sformatf("%0o", val);
            if (k == aip_pkg::KIND_AUTO) body = {"0", body};
        end else if (k == aip_pkg::KIND_BIN) begin
            radix_n = 2;
            body = $sformatf("%0b", val);
        end else begin
            radix_n = 10;
            body = $sformatf("%0d", val);
        end

        // extra digits push past the 32-bit range
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 3))
                body = {body, string'(digit_char($urandom_range(0, radix_n - 1)))};
        // rare long digit runs reach the width limit
        if ($urandom_range(0, 99) == 0) begin
            n_long = ($urandom_range(0, 3) == 0) ? $urandom_range(300, 600)
                                                 : $urandom_range(20, 80);
            repeat (n_long) body = {body, string'(digit_char($urandom_range(0, radix_n - 1)))};
        end
        // corrupt one character now and then
        if ($urandom_range(0, 7) == 0)
            body[$urandom_range(0, body.len() - 1)] = 8'($urandom);

        send_text(body);

        // terminator: whitespace, any byte, end of input, or run into the next field
        case ($urandom_range(0, 11)) inside
            [0:5]:   send_item(blank_char(), 1'b0);
            [6:8]:   send_item(8'($urandom), 1'b0);
            9:       send_item(aip_pkg::CH_SPACE, 1'b0);
            10:      send_eof();
            default: ;
        endcase
    endtask

    // Result side backpressure: per result, hold ready low for a randomly drawn gap.
    initial begin : result_sink
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = draw_gap(res_burst);
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        int         phase_no;
        int         r;
        logic [2:0] kind;
        logic [9:0] width;

        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = aip_pkg::REG_KIND;
        cfg_ch.data         = '0;
        chr_ch.valid        = 1'b0;
        chr_ch.character    = '0;
        chr_ch.end_of_input = 1'b0;
        res_ch.ready        = 1'b0;
        cur_kind            = aip_pkg::KIND_DEC_S;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset config (signed decimal, width 512): a lone sign ended by a
        // blank, end of input while skipping, CR skipped then a number cut by 'x'.
        send_item(aip_pkg::CH_MINUS, 1'b0);
        send_item(aip_pkg::CH_SPACE, 1'b0);
        send_eof();
        send_item(aip_pkg::CH_CR, 1'b0);
        send_text("+9x");
        send_eof();
        settle();
        // hex: prefix with no digit after it converts to zero
        set_config(aip_pkg::KIND_HEX, 10'd512, 1'b0);
        send_text("0xg");
        send_eof();
        settle();
        // auto base: leading zero picks octal; short result
        set_config(aip_pkg::KIND_AUTO, 10'd512, 1'b1);
        send_text("017 ");
        send_eof();
        settle();
        // unsigned with width 2: "-1" fills the width and wraps, then "2" starts anew
        set_config(aip_pkg::KIND_DEC_U, 10'd2, 1'b0);
        send_text("-12");
        send_eof();
        settle();

        // Random phases. The first few sweep the register extremes, including width 0
        // and widths above the maximum, and the two out-of-range kind codes.
        phase_no = 0;
        while (items_sent < ITEM_TARGET) begin
            case (phase_no)
                0: set_config(aip_pkg::KIND_DEC_S, 10'd1,    1'b0);
                1: set_config(aip_pkg::KIND_AUTO,  10'd512,  1'b1);
                2: set_config(aip_pkg::KIND_OCT,   10'd0,    1'b0);
                3: set_config(aip_pkg::KIND_DEC_U, 10'd1023, 1'b1);
                4: set_config(aip_pkg::KIND_HEX,   10'd513,  1'b0);
                5: set_config(aip_pkg::KIND_BIN,   10'd511,  1'b1);
                6: set_config(KIND_ALIAS_6,        10'd512,  1'b0);
                7: set_config(KIND_ALIAS_7,        10'd3,    1'b1);
                default: begin
                    r = $urandom_range(0, 13);
                    kind = (r < 12) ? 3'(r % (aip_pkg::KIND_BIN + 1))
                                    : 3'(KIND_ALIAS_6 + r - 12);
                    case ($urandom_range(0, 5))
                        0: width = 10'($urandom_range(1, 4));
                        1: width = 10'($urandom);
                        2: width = 10'($urandom_range(10, 40));
                        default: width = 10'd512;
                    endcase
                    set_config(kind, width, $urandom_range(0, 3) == 0);
                end
            endcase
            repeat ($urandom_range(5, 30))
                if (items_sent < ITEM_TARGET) send_number_field();
            send_eof();
            settle();
            phase_no++;
        end

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
